/* rtl/lruol_pkg.sv */
// ---------------------------------------------------------------------------
// lruol_pkg: shared constants for the LRU order list
// Operation codes, fixed field widths and the default list size.
// ---------------------------------------------------------------------------
package lruol_pkg;

	// fixed payload widths
	localparam int OP_W  = 2;
	localparam int POS_W = 6;

	// default number of tracked positions
	localparam int DEF_ENTRIES = 64;

	// operation codes
	localparam logic [OP_W-1:0] OP_EXTRACT = 2'd0;
	localparam logic [OP_W-1:0] OP_POP     = 2'd1;
	localparam logic [OP_W-1:0] OP_PUSH    = 2'd2;

endpackage

/* rtl/lru_order_list.sv */
// ---------------------------------------------------------------------------
// lru_order_list: least-recently-used order over a set of positions
// Circular doubly linked ring in two synchronous link memories (next, prev)
// plus a head register pointing at the LRU position. Supports extract,
// pop of the LRU head and push of a position as MRU.
// ---------------------------------------------------------------------------
//
//  channel | signals                              | direction
//  --------+--------------------------------------+----------
//  in      | in_valid, in_ready, operation,       | into block
//          | position                             |
//  out     | out_valid, out_ready,                | out of block
//          | result_position                      |
//
// Each item starts with a link memory read; extract and pop then write back
// in ST_UNLINK, push in ST_PUSH_A and ST_PUSH_B (two writes to each memory),
// and unused / out-of-range ops go through ST_NOP without a write-back.
// After reset an init sweep writes the ring with in_ready low.
// One result register: a new beat is taken while a result waits; the final
// write-back cycle stalls until the result register is free.
// ---------------------------------------------------------------------------
module lru_order_list
	import lruol_pkg::*;
#(
	parameter int ENTRIES = DEF_ENTRIES
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [OP_W-1:0]  operation,
	input  logic [POS_W-1:0] position,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [POS_W-1:0] result_position
);

	localparam int IW = $clog2(ENTRIES);
	localparam int CW = ((IW > POS_W) ? IW : POS_W) + 1;
	localparam logic [IW-1:0] LAST = IW'(ENTRIES - 1);
	localparam logic [CW-1:0] ENTRIES_C = CW'(ENTRIES);

	// sequencer state codes
	localparam logic [2:0] ST_INIT   = 3'd0;
	localparam logic [2:0] ST_IDLE   = 3'd1;
	localparam logic [2:0] ST_NOP    = 3'd2;
	localparam logic [2:0] ST_UNLINK = 3'd3;
	localparam logic [2:0] ST_PUSH_A = 3'd4;
	localparam logic [2:0] ST_PUSH_B = 3'd5;

	// link memories
	logic [IW-1:0] nxt_mem [ENTRIES];
	logic [IW-1:0] prv_mem [ENTRIES];

	logic [2:0]       state_q, state_d;
	logic [IW-1:0]    init_q;
	logic [IW-1:0]    head_q, head_d;
	logic [IW-1:0]    pos_q;
	logic             pop_q;
	logic             out_valid_q;
	logic [POS_W-1:0] result_q, result_d;

	logic             accept, rd_en, done, out_free, pos_ok;
	logic [CW-1:0]    pos_ext;
	logic [IW-1:0]    pos_idx, tgt, nxt_ra, prv_ra, nxt_rd, prv_rd;
	logic             nxt_we, prv_we;
	logic [IW-1:0]    nxt_wa, nxt_wd, prv_wa, prv_wd, new_head;
	logic [CW-1:0]    res_ext;

	assign in_ready        = (state_q == ST_IDLE);
	assign accept          = in_valid && in_ready;
	assign out_free        = !out_valid_q || out_ready;
	assign out_valid       = out_valid_q;
	assign result_position = result_q;

	// decode the incoming position
	assign pos_ext = CW'(position);
	assign pos_ok  = pos_ext < ENTRIES_C;
	assign pos_idx = pos_ext[IW-1:0];
	assign tgt     = (operation == OP_POP) ? head_q : pos_idx;

	// read addresses: push needs prev of head, unlink needs both links of target
	assign rd_en  = accept;
	assign nxt_ra = tgt;
	assign prv_ra = (operation == OP_PUSH) ? head_q : tgt;

	// head after an unlink
	assign new_head = (pos_q == head_q) ? nxt_rd : head_q;

	// write-back and sequencing
	always_comb begin
		state_d  = state_q;
		head_d   = head_q;
		done     = 1'b0;
		nxt_we   = 1'b0;
		prv_we   = 1'b0;
		nxt_wa   = init_q;
		nxt_wd   = (init_q == LAST) ? '0 : init_q + 1'b1;
		prv_wa   = init_q;
		prv_wd   = (init_q == '0) ? LAST : init_q - 1'b1;
		res_ext  = CW'(head_q);
		unique case (state_q)
			ST_INIT: begin
				nxt_we = 1'b1;
				prv_we = 1'b1;
				if (init_q == LAST) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (accept) begin
					if (operation == OP_POP) state_d = ST_UNLINK;
					else if (operation == OP_EXTRACT && pos_ok) state_d = ST_UNLINK;
					else if (operation == OP_PUSH && pos_ok) state_d = ST_PUSH_A;
					else state_d = ST_NOP;
				end
			end
			ST_NOP: begin
				if (out_free) begin
					done    = 1'b1;
					state_d = ST_IDLE;
				end
			end
			ST_UNLINK: begin
				// next[prev] = next, prev[next] = prev
				nxt_wa  = prv_rd;
				nxt_wd  = nxt_rd;
				prv_wa  = nxt_rd;
				prv_wd  = prv_rd;
				res_ext = pop_q ? CW'(pos_q) : CW'(new_head);
				if (out_free) begin
					nxt_we  = 1'b1;
					prv_we  = 1'b1;
					head_d  = new_head;
					done    = 1'b1;
					state_d = ST_IDLE;
				end
			end
			ST_PUSH_A: begin
				// next[old_mru] = pos, prev[pos] = old_mru
				nxt_wa  = prv_rd;
				nxt_wd  = pos_q;
				prv_wa  = pos_q;
				prv_wd  = prv_rd;
				nxt_we  = 1'b1;
				prv_we  = 1'b1;
				state_d = ST_PUSH_B;
			end
			ST_PUSH_B: begin
				// next[pos] = head, prev[head] = pos (later writes win)
				nxt_wa = pos_q;
				nxt_wd = head_q;
				prv_wa = head_q;
				prv_wd = pos_q;
				if (out_free) begin
					nxt_we  = 1'b1;
					prv_we  = 1'b1;
					done    = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
		result_d = res_ext[POS_W-1:0];
	end

	// link memories, registered read
	always_ff @(posedge clk) begin
		if (nxt_we) nxt_mem[nxt_wa] <= nxt_wd;
		if (rd_en) nxt_rd <= nxt_mem[nxt_ra];
	end

	always_ff @(posedge clk) begin
		if (prv_we) prv_mem[prv_wa] <= prv_wd;
		if (rd_en) prv_rd <= prv_mem[prv_ra];
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_INIT;
			init_q      <= '0;
			head_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			head_q      <= head_d;
			out_valid_q <= done || (out_valid_q && !out_ready);
			if (state_q == ST_INIT) init_q <= init_q + 1'b1;
		end
	end

	// item and result payload
	always_ff @(posedge clk) begin
		if (accept) begin
			pos_q <= tgt;
			pop_q <= (operation == OP_POP);
		end
		if (done) result_q <= result_d;
	end

	// link memories are never written while waiting for a beat
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> (!nxt_we && !prv_we))
		else $error("link write while idle");

	// a result is only produced into a free result register
	assert property (@(posedge clk) disable iff (!arst_n)
		done |-> out_free)
		else $error("result register overrun");

	// head always names a valid position
	assert property (@(posedge clk) disable iff (!arst_n)
		CW'(head_q) < ENTRIES_C)
		else $error("head out of range");

	// push never moves the head
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_PUSH_B && done) |=> $stable(head_q))
		else $error("push changed head");

endmodule
